### rtl/qsu_pkg.sv
package qsu_pkg;

  localparam int unsigned QSU_BUFFER_SIZE = 256;

  typedef logic [7:0] byte_t;

  localparam byte_t QSU_NUL         = 8'h00;
  localparam byte_t QSU_BACKSLASH   = 8'h5C;
  localparam byte_t QSU_DQUOTE      = 8'h22;
  localparam byte_t QSU_SQUOTE      = 8'h27;
  localparam byte_t QSU_LETTER_N    = 8'h6E;
  localparam byte_t QSU_LETTER_R    = 8'h72;
  localparam byte_t QSU_LETTER_T    = 8'h74;
  localparam byte_t QSU_NEWLINE     = 8'h0A;
  localparam byte_t QSU_CR          = 8'h0D;
  localparam byte_t QSU_TAB         = 8'h09;
  localparam byte_t QSU_QUOTE_RESET = 8'h22;

  typedef struct packed {
    byte_t      out_char;
    logic       char_valid;
    logic       done_res;
    logic       unterminated;
    logic       is_empty;
    byte_t      length;
    logic       last;
  } res_t;

  // Up to two results handed from the decoder to the output buffer in the same cycle.
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } dec_push_t;

  typedef struct packed {
    logic  known;
    byte_t value;
  } esc_t;

  function automatic esc_t esc_map(input byte_t b);
    esc_t e;
    e.known = 1'b1;
    case (b)
      QSU_LETTER_N:  e.value = QSU_NEWLINE;
      QSU_LETTER_R:  e.value = QSU_CR;
      QSU_LETTER_T:  e.value = QSU_TAB;
      QSU_BACKSLASH: e.value = QSU_BACKSLASH;
      QSU_DQUOTE:    e.value = QSU_DQUOTE;
      QSU_SQUOTE:    e.value = QSU_SQUOTE;
      default: begin
        e.known = 1'b0;
        e.value = b;
      end
    endcase
    return e;
  endfunction

  function automatic res_t mk_char(input byte_t c, input byte_t len);
    res_t r;
    r = '0;
    r.out_char   = c;
    r.char_valid = 1'b1;
    r.length     = len;
    return r;
  endfunction

  function automatic res_t mk_done(input logic unterm, input logic empty, input byte_t len);
    res_t r;
    r = '0;
    r.done_res     = 1'b1;
    r.unterminated = unterm;
    r.is_empty     = empty;
    r.length       = len;
    return r;
  endfunction

endpackage

### rtl/qsu_byte_if.sv
interface qsu_byte_if;
  import qsu_pkg::*;

  logic  valid;
  logic  ready;
  logic  start_req;
  byte_t in_byte;

  modport source (output valid, output start_req, output in_byte, input ready);
  modport sink (input valid, input start_req, input in_byte, output ready);
endinterface

### rtl/qsu_result_if.sv
interface qsu_result_if;
  import qsu_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_char;
  logic  char_valid;
  logic  done_res;
  logic  unterminated;
  logic  is_empty;
  byte_t length;
  logic  last;

  modport source (
    output valid, output out_char, output char_valid, output done_res,
    output unterminated, output is_empty, output length, output last,
    input ready
  );
  modport sink (
    input valid, input out_char, input char_valid, input done_res,
    input unterminated, input is_empty, input length, input last,
    output ready
  );
endinterface

### rtl/qsu_decode.sv
module qsu_decode #(
  parameter int unsigned BUFFER_SIZE = qsu_pkg::QSU_BUFFER_SIZE
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  qsu_pkg::byte_t    cfg_wr_data,
  qsu_byte_if.sink          byte_chan,
  input  logic [1:0]        buf_free,
  output qsu_pkg::dec_push_t push
);
  import qsu_pkg::*;

  localparam int unsigned CNT_W  = $clog2(BUFFER_SIZE);
  localparam int unsigned WIDE_W = CNT_W + 8;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(BUFFER_SIZE - 1);

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_QUOTE,
    MODE_DONE
  } mode_t;

  mode_t            mode, mode_next, eff_mode;
  logic [CNT_W-1:0] count, count_next, eff_cnt;
  logic [CNT_W:0]   sum1, sum2;
  byte_t            quote_char;
  logic             a_valid;
  logic             a_start;
  byte_t            a_byte;
  logic             a_advance;
  logic [1:0]       n;
  res_t             r0, r1;
  byte_t            len0, len1, len2;
  esc_t             esc;

  function automatic byte_t sat_len(input logic [CNT_W:0] v);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(v);
    return (w > WIDE_W'(255)) ? 8'hFF : w[7:0];
  endfunction

  always_comb begin
    eff_mode   = a_start ? MODE_NORMAL : mode;
    eff_cnt    = a_start ? '0 : count;
    sum1       = {1'b0, eff_cnt} + (CNT_W+1)'(1);
    sum2       = {1'b0, eff_cnt} + (CNT_W+1)'(2);
    len0       = sat_len({1'b0, eff_cnt});
    len1       = sat_len(sum1);
    len2       = sat_len(sum2);
    esc        = esc_map(a_byte);
    n          = 2'd0;
    r0         = '0;
    r1         = '0;
    mode_next  = eff_mode;
    count_next = eff_cnt;
    unique case (eff_mode)
      MODE_NORMAL: begin
        if (a_byte == QSU_NUL || eff_cnt >= CAP) begin
          n         = 2'd1;
          r0        = mk_done(a_byte != quote_char, eff_cnt == '0, len0);
          mode_next = MODE_DONE;
        end else if (a_byte == QSU_BACKSLASH) begin
          mode_next = MODE_ESCAPE;
        end else if (a_byte == quote_char) begin
          mode_next = MODE_QUOTE;
        end else begin
          n          = 2'd1;
          r0         = mk_char(a_byte, len1);
          count_next = sum1[CNT_W-1:0];
        end
      end
      MODE_ESCAPE: begin
        if (a_byte == QSU_NUL) begin
          n         = 2'd1;
          r0        = mk_done(quote_char != QSU_NUL, eff_cnt == '0, len0);
          mode_next = MODE_DONE;
        end else begin
          mode_next = MODE_NORMAL;
          if (esc.known) begin
            n          = 2'd1;
            r0         = mk_char(esc.value, len1);
            count_next = sum1[CNT_W-1:0];
          end else if (sum1 < {1'b0, CAP}) begin
            // keep the backslash while two slots remain
            n          = 2'd2;
            r0         = mk_char(QSU_BACKSLASH, len1);
            r1         = mk_char(a_byte, len2);
            count_next = sum2[CNT_W-1:0];
          end else begin
            n          = 2'd1;
            r0         = mk_char(a_byte, len1);
            count_next = sum1[CNT_W-1:0];
          end
        end
      end
      MODE_QUOTE: begin
        if (a_byte == quote_char) begin
          n          = 2'd1;
          r0         = mk_char(quote_char, len1);
          mode_next  = MODE_NORMAL;
          count_next = sum1[CNT_W-1:0];
        end else begin
          n         = 2'd1;
          r0        = mk_done(1'b0, eff_cnt == '0, len0);
          mode_next = MODE_DONE;
        end
      end
      MODE_DONE: begin
        n = 2'd0;
      end
      default: begin
        n = 2'd0;
      end
    endcase
    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  // Hold the item until the buffer has room for all its results.
  assign a_advance       = a_valid && (buf_free >= n);
  assign byte_chan.ready = !a_valid || a_advance;

  assign push.count  = a_advance ? n : 2'd0;
  assign push.first  = r0;
  assign push.second = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      mode       <= MODE_NORMAL;
      count      <= '0;
      quote_char <= QSU_QUOTE_RESET;
    end else begin
      if (cfg_wr_en) begin
        quote_char <= cfg_wr_data;
      end
      if (a_advance) begin
        mode  <= mode_next;
        count <= count_next;
      end
      if (byte_chan.valid && byte_chan.ready) begin
        a_valid <= 1'b1;
        a_start <= byte_chan.start_req;
        a_byte  <= byte_chan.in_byte;
      end else if (a_advance) begin
        a_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/qsu_out_buf.sv
module qsu_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  qsu_pkg::dec_push_t push,
  output logic [1:0]         buf_free,
  qsu_result_if.source       result_chan
);
  import qsu_pkg::*;

  res_t       entry [2];
  res_t       entry_next [2];
  logic [1:0] cnt, cnt_next, base;
  logic       pop;

  assign buf_free = 2'd2 - cnt;
  assign pop      = (cnt != 2'd0) && result_chan.ready;

  always_comb begin
    base          = cnt - {1'b0, pop};
    entry_next[0] = pop ? entry[1] : entry[0];
    entry_next[1] = entry[1];
    if (push.count == 2'd2) begin
      entry_next[0] = push.first;
      entry_next[1] = push.second;
    end else if (push.count == 2'd1) begin
      entry_next[base[0]] = push.first;
    end
    cnt_next = base + push.count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt      <= cnt_next;
      entry[0] <= entry_next[0];
      entry[1] <= entry_next[1];
    end
  end

  assign result_chan.valid        = cnt != 2'd0;
  assign result_chan.out_char     = entry[0].out_char;
  assign result_chan.char_valid   = entry[0].char_valid;
  assign result_chan.done_res     = entry[0].done_res;
  assign result_chan.unterminated = entry[0].unterminated;
  assign result_chan.is_empty     = entry[0].is_empty;
  assign result_chan.length       = entry[0].length;
  assign result_chan.last         = entry[0].last;

endmodule

### rtl/quoted_string_unescape_core.sv
// Quoted literal unescape core.
// byte_chan takes one source byte per request, starting with the byte after
// the opening quote; start_req on a request clears the decoder first. A zero
// byte marks the end of the source text.
// result_chan gives one request per decoded character or one done request
// when the literal ends; last marks the final result of each source byte.
// A quote byte or a backslash gives no result until the next byte decides.
// quote_char must be written through cfg_wr_en / cfg_wr_data only while idle;
// the user must keep to this, as the block itself does not enforce it.
// An accepted byte is decoded from the input register and its first result
// is loaded into the result buffer. Throughput: one byte per cycle while the
// buffer has room; an unknown escape that keeps its backslash yields two
// results and may hold the input while the two-entry result buffer drains.
// Reset clears the decoder to its normal mode, the count to zero and
// quote_char to the double quote; no result is pending afterward.
// When the receiver stalls, the buffer fills and the input stage holds the
// first byte that has results, so byte_chan.ready stays low until the buffer
// has room; bytes that give no result still pass. Nothing is lost.
module quoted_string_unescape_core #(
  parameter int unsigned BUFFER_SIZE = qsu_pkg::QSU_BUFFER_SIZE
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  qsu_pkg::byte_t cfg_wr_data,
  qsu_byte_if.sink       byte_chan,
  qsu_result_if.source   result_chan
);
  import qsu_pkg::*;

  dec_push_t  push;
  logic [1:0] buf_free;

  qsu_decode #(
    .BUFFER_SIZE(BUFFER_SIZE)
  ) u_decode (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .byte_chan  (byte_chan),
    .buf_free   (buf_free),
    .push       (push)
  );

  qsu_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .buf_free   (buf_free),
    .result_chan(result_chan)
  );

endmodule
